/* rtl/pqadc_pkg.sv */
// ----------------------------------------------------------------------------
// pqadc_pkg
// Shared types and constants of the PQ asymmetric distance scanner.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pqadc_pkg;

  // Distance table geometry.
  localparam int TABLE_DEPTH = 16384;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);

  // Field widths.
  localparam int BYTE_W   = 8;
  localparam int ROW_W    = 32;
  localparam int SUM_W    = 16;
  localparam int SQ_W     = 9;
  localparam int NB_W     = 4;
  localparam int CODE_W   = 12;
  localparam int BUF_W    = 20;
  localparam int HELD_W   = 5;
  localparam int ADDR_FULL_W = SQ_W + CODE_W;

  // Limits of the configuration registers.
  localparam logic [SQ_W-1:0] MAX_SQ  = SQ_W'(256);
  localparam logic [NB_W-1:0] MAX_NB  = NB_W'(12);
  localparam logic [NB_W-1:0] MIN_NB  = NB_W'(1);
  localparam logic [SUM_W-1:0] SUM_MAX = '1;

  // Configuration port.
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 9;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_SQ    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_CODE_BITS = CFG_IDX_W'(1);

  // Reset values of the configuration registers.
  localparam logic [SQ_W-1:0] NUM_SQ_RST    = SQ_W'(8);
  localparam logic [NB_W-1:0] CODE_BITS_RST = NB_W'(8);

  // Request modes.
  localparam logic MODE_TABLE_WRITE = 1'b0;
  localparam logic MODE_CODE_BYTE   = 1'b1;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic tbl_wr;
    logic load_byte;
    logic step;
    logic cfg_wr;
    logic emit;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic can_step;
    logic rd_pend;
    logic complete;
    logic out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

/* rtl/pq_adc_distance_scanner.sv */
// ----------------------------------------------------------------------------
// pq_adc_distance_scanner
// Product-quantization asymmetric distance scanner: table load, packed code
// unpacking and saturating distance summation.
// ----------------------------------------------------------------------------
// A table-write request is done in the idle state. A code-byte request
// loads the byte, steps once for each sub-code that the byte completes,
// and closes in the finish state. The distance table has a single read
// port, one lookup per cycle. A finished result sits in an output
// register, and the next request is taken while it waits; only a second
// result stalls until the first has been taken. Table entries are
// undefined until written and need no clearing pass after reset.
`timescale 1ns / 1ps
`default_nettype none

module pq_adc_distance_scanner
  import pqadc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic                  in_mode,
  input  wire logic [ADDR_W-1:0]     in_table_address,
  input  wire logic [BYTE_W-1:0]     in_table_value,
  input  wire logic [BYTE_W-1:0]     in_code_byte,
  input  wire logic [ROW_W-1:0]      in_row_id,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [ROW_W-1:0]           out_row_id,
  output logic [SUM_W-1:0]           out_distance_sum,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  // Controller.
  pqadc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_mode   (in_mode),
    .cfg_valid (cfg_valid),
    .sts       (sts),
    .in_stall  (in_stall),
    .cfg_ready (cfg_ready),
    .cmd       (cmd)
  );

  // Datapath.
  pqadc_datapath u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_table_address (in_table_address),
    .in_table_value   (in_table_value),
    .in_code_byte     (in_code_byte),
    .in_row_id        (in_row_id),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_row_id       (out_row_id),
    .out_distance_sum (out_distance_sum)
  );

endmodule

`default_nettype wire

/* rtl/pqadc_ctrl.sv */
// ----------------------------------------------------------------------------
// pqadc_ctrl
// Controller that sequences table writes, byte loads, sub-code steps and
// result hand-off for the distance scanner datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pqadc_ctrl
  import pqadc_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  input  wire logic    in_mode,
  input  wire logic    cfg_valid,
  input  wire dp_sts_t sts,
  output logic         in_stall,
  output logic         cfg_ready,
  output dp_cmd_t      cmd
);

  state_t state_r;
  state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && !cfg_valid && in_mode == MODE_CODE_BYTE) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!sts.can_step) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!sts.rd_pend) begin
          if (!sts.complete || sts.out_free) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Outputs.
  always_comb begin
    cmd       = '0;
    in_stall  = 1'b1;
    cfg_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        // Configuration writes take priority over an item in the same cycle.
        cfg_ready  = 1'b1;
        in_stall   = cfg_valid;
        cmd.cfg_wr = cfg_valid;
        if (in_valid && !cfg_valid) begin
          cmd.load_byte = (in_mode == MODE_CODE_BYTE);
          cmd.tbl_wr    = (in_mode == MODE_TABLE_WRITE);
        end
      end
      ST_SCAN: begin
        cmd.step = sts.can_step;
      end
      ST_FINISH: begin
        cmd.emit = !sts.rd_pend && sts.complete && sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/pqadc_datapath.sv */
// ----------------------------------------------------------------------------
// pqadc_datapath
// Distance table memory, bit buffer unpacker, saturating accumulator,
// configuration registers and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pqadc_datapath
  import pqadc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire dp_cmd_t               cmd,
  output dp_sts_t                    sts,
  input  wire logic [ADDR_W-1:0]     in_table_address,
  input  wire logic [BYTE_W-1:0]     in_table_value,
  input  wire logic [BYTE_W-1:0]     in_code_byte,
  input  wire logic [ROW_W-1:0]      in_row_id,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  out_stall,
  output logic                       out_valid,
  output logic [ROW_W-1:0]           out_row_id,
  output logic [SUM_W-1:0]           out_distance_sum
);

  // Distance table; entries are undefined until written.
  logic [BYTE_W-1:0] table_mem [TABLE_DEPTH];
  logic [BYTE_W-1:0] rd_q_r;

  // Configuration registers.
  logic [SQ_W-1:0] num_sq_r;
  logic [NB_W-1:0] code_bits_r;

  // Streaming state.
  logic [BUF_W-1:0]  bitbuf_r,  bitbuf_nxt;
  logic [HELD_W-1:0] held_r,    held_nxt;
  logic [SQ_W-1:0]   sub_idx_r, sub_idx_nxt;
  logic [SUM_W-1:0]  sum_r,     sum_nxt;
  logic [ROW_W-1:0]  row_r;
  logic              rd_pend_r;

  // Result register.
  logic              out_valid_r;
  logic [ROW_W-1:0]  out_row_r;
  logic [SUM_W-1:0]  out_sum_r;

  logic [NB_W-1:0]        nb_eff;
  logic [SQ_W-1:0]        m_eff;
  logic [CODE_W:0]        mask_full;
  logic [CODE_W-1:0]      code;
  logic [ADDR_FULL_W-1:0] addr_full;
  logic [ADDR_W-1:0]      rd_addr;
  logic [SUM_W:0]         sum_wide;
  logic                   complete;
  logic                   cfg_clear;

  // Clamp the configuration registers to their working ranges.
  always_comb begin
    if (code_bits_r == '0) begin
      nb_eff = MIN_NB;
    end else if (code_bits_r > MAX_NB) begin
      nb_eff = MAX_NB;
    end else begin
      nb_eff = code_bits_r;
    end
    if (num_sq_r == '0) begin
      m_eff = SQ_W'(1);
    end else if (num_sq_r > MAX_SQ) begin
      m_eff = MAX_SQ;
    end else begin
      m_eff = num_sq_r;
    end
  end

  // Sub-code extraction and table address.
  always_comb begin
    mask_full = ((CODE_W + 1)'(1) << nb_eff) - (CODE_W + 1)'(1);
    code      = bitbuf_r[CODE_W-1:0] & mask_full[CODE_W-1:0];
    addr_full = ({{CODE_W{1'b0}}, sub_idx_r} << nb_eff)
                + {{SQ_W{1'b0}}, code};
    rd_addr   = addr_full[ADDR_W-1:0];
  end

  assign complete = (sub_idx_r >= m_eff);

  // Only a write to one of the two registers abandons the partial vector.
  assign cfg_clear = cmd.cfg_wr &&
                     (cfg_index == CFG_NUM_SQ || cfg_index == CFG_CODE_BITS);

  // Status to the controller.
  always_comb begin
    sts.can_step = !complete && (held_r >= {1'b0, nb_eff});
    sts.rd_pend  = rd_pend_r;
    sts.complete = complete;
    sts.out_free = !out_valid_r || !out_stall;
  end

  // Single-port table: a write or a registered read each cycle.
  always_ff @(posedge clk) begin
    if (cmd.tbl_wr) begin
      table_mem[in_table_address] <= in_table_value;
    end else if (cmd.step) begin
      rd_q_r <= table_mem[rd_addr];
    end
  end

  // Saturating accumulation of the looked-up byte.
  always_comb begin
    sum_wide = {1'b0, sum_r} + {{(SUM_W + 1 - BYTE_W){1'b0}}, rd_q_r};
  end

  // Next values of the streaming state.
  always_comb begin
    bitbuf_nxt  = bitbuf_r;
    held_nxt    = held_r;
    sub_idx_nxt = sub_idx_r;
    sum_nxt     = sum_r;
    if (rd_pend_r) begin
      sum_nxt = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
    end
    if (cfg_clear || cmd.emit) begin
      bitbuf_nxt  = '0;
      held_nxt    = '0;
      sub_idx_nxt = '0;
      sum_nxt     = '0;
    end else if (cmd.load_byte) begin
      bitbuf_nxt = bitbuf_r | ({{(BUF_W - BYTE_W){1'b0}}, in_code_byte} << held_r);
      held_nxt   = held_r + HELD_W'(BYTE_W);
    end else if (cmd.step) begin
      bitbuf_nxt  = bitbuf_r >> nb_eff;
      held_nxt    = held_r - {1'b0, nb_eff};
      sub_idx_nxt = sub_idx_r + SQ_W'(1);
    end
  end

  // Streaming state and configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bitbuf_r    <= '0;
      held_r      <= '0;
      sub_idx_r   <= '0;
      sum_r       <= '0;
      rd_pend_r   <= 1'b0;
      num_sq_r    <= NUM_SQ_RST;
      code_bits_r <= CODE_BITS_RST;
    end else begin
      bitbuf_r  <= bitbuf_nxt;
      held_r    <= held_nxt;
      sub_idx_r <= sub_idx_nxt;
      sum_r     <= sum_nxt;
      rd_pend_r <= cmd.step;
      if (cmd.cfg_wr) begin
        case (cfg_index)
          CFG_NUM_SQ: begin
            num_sq_r <= cfg_data[SQ_W-1:0];
          end
          CFG_CODE_BITS: begin
            code_bits_r <= cfg_data[NB_W-1:0];
          end
          default: begin
            num_sq_r <= num_sq_r;
          end
        endcase
      end
    end
  end

  // Row id of the vector that is streaming.
  always_ff @(posedge clk) begin
    if (cmd.load_byte) begin
      row_r <= in_row_id;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_row_r <= row_r;
      out_sum_r <= sum_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_row_id       = out_row_r;
  assign out_distance_sum = out_sum_r;

  // The bit buffer never holds more than a byte plus a partial sub-code.
  a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= HELD_W'(19))
    else $error("bit count exceeds buffer capacity");

  // A table read is only issued for a sub-code that belongs to the vector.
  a_step_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> (sub_idx_r < m_eff) && !cmd.tbl_wr)
    else $error("sub-code step outside the vector");

  // A result leaves only once every sub-code has been summed.
  a_emit_complete: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> complete && !rd_pend_r)
    else $error("result emitted before all sub-codes were summed");

  // Emitting a result restarts the stream on a byte boundary.
  a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> (held_r == '0) && (sum_r == '0) && (sub_idx_r == '0) && out_valid_r)
    else $error("stream state not cleared after a result");

endmodule

`default_nettype wire
